// ===== sv/leap_pkg.sv =====
// ============================================================================
// leap_pkg
// Shared constants and helpers for the Lambert equal-area projector.
// ============================================================================
package leap_pkg;

    localparam int COORD_BITS_DEF    = 16;
    localparam int OUT_FRAC_BITS_DEF = 16;

    // Magnitude normalization window is [2^14, 2^15]
    localparam int MAX_COORD_BITS = 32;
    localparam int SHIFT_BITS     = 5;
    localparam int NORM_BITS      = 16;
    localparam int NORM_LOW_POS   = 14;
    localparam int NORM_TOP_POS   = 15;

    localparam int SQ_BITS      = 2 * NORM_BITS;
    localparam int ROOT_IN_BITS = 2 * SQ_BITS;
    localparam int ROOT_BITS    = SQ_BITS;
    localparam int ZS_SHIFT     = 16;
    localparam int D_BITS       = ROOT_BITS + 1;
    localparam int W_SHIFT      = 30;
    localparam int W_QBITS      = W_SHIFT + 1;
    localparam int PROD_BITS    = 2 * ROOT_BITS;
    localparam int PLACE_BASE   = 14;

    // Sideband bundles carried along the cell rows
    localparam int FLAG_BITS = 4;
    localparam int SIDE1_W   = FLAG_BITS + 3 * NORM_BITS + SQ_BITS;
    localparam int SIDE2_W   = FLAG_BITS + 2 * NORM_BITS + SQ_BITS + ROOT_BITS;
    localparam int SIDE3_W   = FLAG_BITS + 2 * NORM_BITS;

    function automatic logic [SHIFT_BITS-1:0] msb_pos(input logic [MAX_COORD_BITS-1:0] m);
        logic [SHIFT_BITS-1:0] p;
        p = '0;
        for (int i = 0; i < MAX_COORD_BITS; i++) begin
            if (m[i]) begin
                p = SHIFT_BITS'(i);
            end
        end
        return p;
    endfunction

    // Right-shift amount that lands the maximum in the window; one less when
    // the truncated value hits the top of the window exactly.
    function automatic logic [SHIFT_BITS-1:0] norm_shift(
        input logic [MAX_COORD_BITS-1:0] m,
        input logic [SHIFT_BITS-1:0]     p
    );
        logic exact;
        exact = (p >= SHIFT_BITS'(NORM_TOP_POS)) &&
                ((m >> (p - SHIFT_BITS'(NORM_TOP_POS))) ==
                 (MAX_COORD_BITS'(1) << NORM_TOP_POS));
        return exact ? (p - SHIFT_BITS'(1)) : p;
    endfunction

endpackage

// ===== sv/leap_pos_if.sv =====
// ============================================================================
// leap_pos_if
// Request channel carrying one signed 3D position.
// ============================================================================
interface leap_pos_if import leap_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

// ===== sv/leap_proj_if.sv =====
// ============================================================================
// leap_proj_if
// Result channel carrying the projected coordinates and the invalid flag.
// ============================================================================
interface leap_proj_if import leap_pkg::*; #(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) ();
    logic                     valid;
    logic                     ready;
    logic [OUT_FRAC_BITS-1:0] proj_u;
    logic [OUT_FRAC_BITS-1:0] proj_v;
    logic                     invalid;

    modport source (output valid, output proj_u, output proj_v, output invalid, input ready);
    modport sink   (input valid, input proj_u, input proj_v, input invalid, output ready);
endinterface

// ===== sv/lambert_equal_area_projector.sv =====
// ============================================================================
// lambert_equal_area_projector
// Lambert azimuthal equal-area projection about the minus-z pole.
// ============================================================================
// Throughput: one request per cycle while not stalled; set by the root and divider
// cell rows, which advance one digit per cell per cycle.
// A full output register stalls the rows only while a result waits behind it.
// Reset clears the valid bits of all stages; the data path registers are not reset.
module lambert_equal_area_projector import leap_pkg::*; #(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    leap_pos_if.sink    pos,
    leap_proj_if.source proj
);
    localparam int CB  = COORD_BITS;
    localparam int OFB = OUT_FRAC_BITS;
    localparam int PQ  = OFB + 2;
    localparam int NW  = OFB + 31;
    localparam int PLACE_SHIFT = PLACE_BASE + OFB;
    localparam logic [OFB-1:0] HALF = OFB'(1) << (OFB - 1);
    localparam logic [OFB:0]   TOP  = (OFB + 1)'((OFB + 1)'(1) << OFB) - (OFB + 1)'(1);
    localparam logic [ROOT_BITS-1:0] Q_MIN = ROOT_BITS'(1) << 28;

    function automatic logic [NORM_BITS-1:0] norm_mag(
        input logic [CB-1:0]         m,
        input logic [SHIFT_BITS-1:0] t
    );
        logic [CB+NORM_LOW_POS-1:0] w;
        w = {m, {NORM_LOW_POS{1'b0}}} >> t;
        return NORM_BITS'(w);
    endfunction

    logic en;
    logic last_vld;
    logic out_vld_reg;

    // Freeze every stage only when a finished result is blocked behind a full output
    assign en        = !(out_vld_reg && !proj.ready && last_vld);
    assign pos.ready = en;

    // ---------------- front end: capture, magnitudes, normalization --------
    logic                 s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic                 s5_vld_reg, s6_vld_reg, s7_vld_reg;
    logic signed [CB-1:0] s1_x_reg, s1_y_reg, s1_z_reg;

    logic [CB-1:0] ax_next, ay_next, az_next, maxf_next, maxp_next;
    logic [FLAG_BITS-1:0] flags_next;
    logic [CB-1:0] s2_ax_reg, s2_ay_reg, s2_az_reg, s2_maxf_reg, s2_maxp_reg;
    logic [FLAG_BITS-1:0] s2_flags_reg, s3_flags_reg, s4_flags_reg;
    logic [FLAG_BITS-1:0] s5_flags_reg, s6_flags_reg, s7_flags_reg;

    logic [CB-1:0] s3_ax_reg, s3_ay_reg, s3_az_reg, s3_maxf_reg, s3_maxp_reg;
    logic [SHIFT_BITS-1:0] s3_pf_reg, s3_pp_reg;
    logic [CB-1:0] s4_ax_reg, s4_ay_reg, s4_az_reg;
    logic [SHIFT_BITS-1:0] s4_tf_reg, s4_tp_reg;

    logic [NORM_BITS-1:0] fx_next, fy_next, fz_next, cx_next, cy_next;
    logic [NORM_BITS-1:0] s5_fx_reg, s5_fy_reg, s5_fz_reg, s5_cx_reg, s5_cy_reg;
    logic [SQ_BITS-1:0]   s6_sqx_reg, s6_sqy_reg, s6_sqz_reg, s6_sqcx_reg, s6_sqcy_reg;
    logic [NORM_BITS-1:0] s6_fz_reg, s6_cx_reg, s6_cy_reg;
    logic [SQ_BITS-1:0]   s7_s_reg, s7_ps_reg;
    logic [NORM_BITS-1:0] s7_fz_reg, s7_cx_reg, s7_cy_reg;

    // flags: {invalid, z positive, x negative, y negative}
    always_comb
    begin
        ax_next = s1_x_reg[CB-1] ? $unsigned(-s1_x_reg) : $unsigned(s1_x_reg);
        ay_next = s1_y_reg[CB-1] ? $unsigned(-s1_y_reg) : $unsigned(s1_y_reg);
        az_next = s1_z_reg[CB-1] ? $unsigned(-s1_z_reg) : $unsigned(s1_z_reg);
        maxp_next = (ax_next > ay_next) ? ax_next : ay_next;
        maxf_next = (maxp_next > az_next) ? maxp_next : az_next;
        flags_next = {(s1_x_reg == '0) && (s1_y_reg == '0) && !s1_z_reg[CB-1],
                      !s1_z_reg[CB-1] && (s1_z_reg != '0),
                      s1_x_reg[CB-1], s1_y_reg[CB-1]};
    end

    always_comb
    begin
        fx_next = norm_mag(s4_ax_reg, s4_tf_reg);
        fy_next = norm_mag(s4_ay_reg, s4_tf_reg);
        fz_next = norm_mag(s4_az_reg, s4_tf_reg);
        // Above the equator x and y are renormalized on their own
        cx_next = s4_flags_reg[2] ? norm_mag(s4_ax_reg, s4_tp_reg) : fx_next;
        cy_next = s4_flags_reg[2] ? norm_mag(s4_ay_reg, s4_tp_reg) : fy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= pos.valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x_reg <= pos.pos_x;
            s1_y_reg <= pos.pos_y;
            s1_z_reg <= pos.pos_z;

            s2_ax_reg    <= ax_next;
            s2_ay_reg    <= ay_next;
            s2_az_reg    <= az_next;
            s2_maxf_reg  <= maxf_next;
            s2_maxp_reg  <= maxp_next;
            s2_flags_reg <= flags_next;

            s3_ax_reg    <= s2_ax_reg;
            s3_ay_reg    <= s2_ay_reg;
            s3_az_reg    <= s2_az_reg;
            s3_maxf_reg  <= s2_maxf_reg;
            s3_maxp_reg  <= s2_maxp_reg;
            s3_pf_reg    <= msb_pos(MAX_COORD_BITS'(s2_maxf_reg));
            s3_pp_reg    <= msb_pos(MAX_COORD_BITS'(s2_maxp_reg));
            s3_flags_reg <= s2_flags_reg;

            s4_ax_reg    <= s3_ax_reg;
            s4_ay_reg    <= s3_ay_reg;
            s4_az_reg    <= s3_az_reg;
            s4_tf_reg    <= norm_shift(MAX_COORD_BITS'(s3_maxf_reg), s3_pf_reg);
            s4_tp_reg    <= norm_shift(MAX_COORD_BITS'(s3_maxp_reg), s3_pp_reg);
            s4_flags_reg <= s3_flags_reg;

            s5_fx_reg    <= fx_next;
            s5_fy_reg    <= fy_next;
            s5_fz_reg    <= fz_next;
            s5_cx_reg    <= cx_next;
            s5_cy_reg    <= cy_next;
            s5_flags_reg <= s4_flags_reg;

            s6_sqx_reg   <= SQ_BITS'(s5_fx_reg) * SQ_BITS'(s5_fx_reg);
            s6_sqy_reg   <= SQ_BITS'(s5_fy_reg) * SQ_BITS'(s5_fy_reg);
            s6_sqz_reg   <= SQ_BITS'(s5_fz_reg) * SQ_BITS'(s5_fz_reg);
            s6_sqcx_reg  <= SQ_BITS'(s5_cx_reg) * SQ_BITS'(s5_cx_reg);
            s6_sqcy_reg  <= SQ_BITS'(s5_cy_reg) * SQ_BITS'(s5_cy_reg);
            s6_fz_reg    <= s5_fz_reg;
            s6_cx_reg    <= s5_cx_reg;
            s6_cy_reg    <= s5_cy_reg;
            s6_flags_reg <= s5_flags_reg;

            s7_s_reg     <= s6_sqx_reg + s6_sqy_reg + s6_sqz_reg;
            s7_ps_reg    <= s6_sqcx_reg + s6_sqcy_reg;
            s7_fz_reg    <= s6_fz_reg;
            s7_cx_reg    <= s6_cx_reg;
            s7_cy_reg    <= s6_cy_reg;
            s7_flags_reg <= s6_flags_reg;
        end
    end

    // ---------------- first root: R = isqrt(S << 32) -----------------------
    logic                    r1_vld  [0:ROOT_BITS];
    logic [ROOT_IN_BITS-1:0] r1_a    [0:ROOT_BITS];
    logic [ROOT_IN_BITS-1:0] r1_res  [0:ROOT_BITS];
    logic [SIDE1_W-1:0]      r1_side [0:ROOT_BITS];

    assign r1_vld[0]  = s7_vld_reg;
    assign r1_a[0]    = {s7_s_reg, {SQ_BITS{1'b0}}};
    assign r1_res[0]  = '0;
    assign r1_side[0] = {s7_flags_reg, s7_fz_reg, s7_cx_reg, s7_cy_reg, s7_ps_reg};

    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_root1
        leap_sqrt_cell #(.IW(ROOT_IN_BITS), .STEP(k), .SW(SIDE1_W)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .vld_i  (r1_vld[k]),
            .a_i    (r1_a[k]),
            .res_i  (r1_res[k]),
            .side_i (r1_side[k]),
            .vld_o  (r1_vld[k+1]),
            .a_o    (r1_a[k+1]),
            .res_o  (r1_res[k+1]),
            .side_o (r1_side[k+1])
        );
    end

    // ---------------- R + Zs, then W = (R << 30) / (R + Zs) ----------------
    logic [FLAG_BITS-1:0] r1_flags;
    logic [NORM_BITS-1:0] r1_fz, r1_cx, r1_cy;
    logic [SQ_BITS-1:0]   r1_ps;
    logic [ROOT_BITS-1:0] r1_root;

    logic                 s8_vld_reg;
    logic [ROOT_BITS-1:0] s8_r_reg;
    logic [D_BITS-1:0]    s8_d_reg;
    logic [SIDE2_W-1:0]   s8_side_reg;
    logic [ROOT_BITS+W_SHIFT-1:0] s8_n;

    assign {r1_flags, r1_fz, r1_cx, r1_cy, r1_ps} = r1_side[ROOT_BITS];
    assign r1_root = r1_res[ROOT_BITS][ROOT_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s8_vld_reg <= r1_vld[ROOT_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_r_reg    <= r1_root;
            s8_d_reg    <= {1'b0, r1_root} + {1'b0, r1_fz, {ZS_SHIFT{1'b0}}};
            s8_side_reg <= {r1_flags, r1_cx, r1_cy, r1_ps, r1_root};
        end
    end

    assign s8_n = {s8_r_reg, {W_SHIFT{1'b0}}};

    logic               w_vld  [0:W_QBITS];
    logic [D_BITS-1:0]  w_d    [0:W_QBITS];
    logic [D_BITS-1:0]  w_rem  [0:W_QBITS];
    logic [W_QBITS-1:0] w_lq   [0:W_QBITS];
    logic [SIDE2_W-1:0] w_side [0:W_QBITS];

    assign w_vld[0]  = s8_vld_reg;
    assign w_d[0]    = s8_d_reg;
    assign w_rem[0]  = D_BITS'(s8_n >> W_QBITS);
    assign w_lq[0]   = s8_n[W_QBITS-1:0];
    assign w_side[0] = s8_side_reg;

    for (genvar k = 0; k < W_QBITS; k++)
    begin : g_wdiv
        leap_div_cell #(.DW(D_BITS), .QW(W_QBITS), .SW(SIDE2_W)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .vld_i  (w_vld[k]),
            .d_i    (w_d[k]),
            .rem_i  (w_rem[k]),
            .lq_i   (w_lq[k]),
            .side_i (w_side[k]),
            .vld_o  (w_vld[k+1]),
            .d_o    (w_d[k+1]),
            .rem_o  (w_rem[k+1]),
            .lq_o   (w_lq[k+1]),
            .side_o (w_side[k+1])
        );
    end

    // ---------------- radicand product ----------------------------------
    logic [FLAG_BITS-1:0] w_flags;
    logic [NORM_BITS-1:0] w_cx, w_cy;
    logic [SQ_BITS-1:0]   w_ps;
    logic [ROOT_BITS-1:0] w_r;
    logic [ROOT_BITS-1:0] mul_a, mul_b;

    logic                 s9_vld_reg;
    logic [PROD_BITS-1:0] s9_prod_reg;
    logic [SIDE3_W-1:0]   s9_side_reg;

    assign {w_flags, w_cx, w_cy, w_ps, w_r} = w_side[W_QBITS];

    always_comb
    begin
        if (w_flags[2])
        begin
            mul_a = w_ps;
            mul_b = ROOT_BITS'(w_lq[W_QBITS]);
        end
        else
        begin
            mul_a = w_r;
            mul_b = w_d[W_QBITS][D_BITS-1:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s9_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s9_vld_reg <= w_vld[W_QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_prod_reg <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
            s9_side_reg <= {w_flags, w_cx, w_cy};
        end
    end

    // ---------------- second root: Q -------------------------------------
    logic                    r2_vld  [0:ROOT_BITS];
    logic [ROOT_IN_BITS-1:0] r2_a    [0:ROOT_BITS];
    logic [ROOT_IN_BITS-1:0] r2_res  [0:ROOT_BITS];
    logic [SIDE3_W-1:0]      r2_side [0:ROOT_BITS];

    assign r2_vld[0]  = s9_vld_reg;
    assign r2_a[0]    = s9_side_reg[SIDE3_W-2] ? (s9_prod_reg << 1) : s9_prod_reg;
    assign r2_res[0]  = '0;
    assign r2_side[0] = s9_side_reg;

    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_root2
        leap_sqrt_cell #(.IW(ROOT_IN_BITS), .STEP(k), .SW(SIDE3_W)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .vld_i  (r2_vld[k]),
            .a_i    (r2_a[k]),
            .res_i  (r2_res[k]),
            .side_i (r2_side[k]),
            .vld_o  (r2_vld[k+1]),
            .a_o    (r2_a[k+1]),
            .res_o  (r2_res[k+1]),
            .side_o (r2_side[k+1])
        );
    end

    // ---------------- rounded offsets: (|c| << (14+OFB) + Q/2) / Q ----------
    logic [FLAG_BITS-1:0] r2_flags;
    logic [NORM_BITS-1:0] r2_cx, r2_cy;
    logic [ROOT_BITS-1:0] r2_q;

    logic                 s10_vld_reg;
    logic [ROOT_BITS-1:0] s10_q_reg;
    logic [NW-1:0]        s10_nu_reg, s10_nv_reg;
    logic                 s10_inv_reg, s10_nx_reg, s10_ny_reg;

    assign {r2_flags, r2_cx, r2_cy} = r2_side[ROOT_BITS];
    assign r2_q = r2_res[ROOT_BITS][ROOT_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s10_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s10_vld_reg <= r2_vld[ROOT_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10_q_reg   <= r2_q;
            s10_nu_reg  <= (NW'(r2_cx) << PLACE_SHIFT) + NW'(r2_q >> 1);
            s10_nv_reg  <= (NW'(r2_cy) << PLACE_SHIFT) + NW'(r2_q >> 1);
            s10_inv_reg <= r2_flags[3];
            s10_nx_reg  <= r2_flags[1];
            s10_ny_reg  <= r2_flags[0];
        end
    end

    logic                 du_vld  [0:PQ];
    logic [ROOT_BITS-1:0] du_d    [0:PQ];
    logic [ROOT_BITS-1:0] du_rem  [0:PQ];
    logic [PQ-1:0]        du_lq   [0:PQ];
    logic [1:0]           du_side [0:PQ];
    logic                 dv_vld  [0:PQ];
    logic [ROOT_BITS-1:0] dv_d    [0:PQ];
    logic [ROOT_BITS-1:0] dv_rem  [0:PQ];
    logic [PQ-1:0]        dv_lq   [0:PQ];
    logic [0:0]           dv_side [0:PQ];

    assign du_vld[0]  = s10_vld_reg;
    assign du_d[0]    = s10_q_reg;
    assign du_rem[0]  = ROOT_BITS'(s10_nu_reg >> PQ);
    assign du_lq[0]   = s10_nu_reg[PQ-1:0];
    assign du_side[0] = {s10_inv_reg, s10_nx_reg};
    assign dv_vld[0]  = s10_vld_reg;
    assign dv_d[0]    = s10_q_reg;
    assign dv_rem[0]  = ROOT_BITS'(s10_nv_reg >> PQ);
    assign dv_lq[0]   = s10_nv_reg[PQ-1:0];
    assign dv_side[0] = s10_ny_reg;

    for (genvar k = 0; k < PQ; k++)
    begin : g_place
        leap_div_cell #(.DW(ROOT_BITS), .QW(PQ), .SW(2)) u_cell_u (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .vld_i  (du_vld[k]),
            .d_i    (du_d[k]),
            .rem_i  (du_rem[k]),
            .lq_i   (du_lq[k]),
            .side_i (du_side[k]),
            .vld_o  (du_vld[k+1]),
            .d_o    (du_d[k+1]),
            .rem_o  (du_rem[k+1]),
            .lq_o   (du_lq[k+1]),
            .side_o (du_side[k+1])
        );
        leap_div_cell #(.DW(ROOT_BITS), .QW(PQ), .SW(1)) u_cell_v (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .vld_i  (dv_vld[k]),
            .d_i    (dv_d[k]),
            .rem_i  (dv_rem[k]),
            .lq_i   (dv_lq[k]),
            .side_i (dv_side[k]),
            .vld_o  (dv_vld[k+1]),
            .d_o    (dv_d[k+1]),
            .rem_o  (dv_rem[k+1]),
            .lq_o   (dv_lq[k+1]),
            .side_o (dv_side[k+1])
        );
    end

    // ---------------- center, clamp and output register ----------------------
    logic           fin_inv, fin_nx, fin_ny;
    logic [PQ-1:0]  off_u, off_v;
    logic [OFB-1:0] u_next, v_next;
    logic [OFB-1:0] proj_u_reg, proj_v_reg;
    logic           invalid_reg;

    assign {fin_inv, fin_nx} = du_side[PQ];
    assign fin_ny   = dv_side[PQ][0];
    assign off_u    = du_lq[PQ];
    assign off_v    = dv_lq[PQ];
    assign last_vld = du_vld[PQ];

    function automatic logic [OFB-1:0] center(input logic [PQ-1:0] off, input logic neg);
        logic [PQ:0] up;
        logic [OFB-1:0] res;
        up = (PQ + 1)'(off) + (PQ + 1)'(HALF);
        if (neg)
        begin
            res = (off > PQ'(HALF)) ? '0 : OFB'(PQ'(HALF) - off);
        end
        else
        begin
            res = (up > (PQ + 1)'(TOP)) ? OFB'(TOP) : OFB'(up);
        end
        return res;
    endfunction

    always_comb
    begin
        if (fin_inv)
        begin
            u_next = HALF;
            v_next = HALF;
        end
        else
        begin
            u_next = center(off_u, fin_nx);
            v_next = center(off_v, fin_ny);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || proj.ready)
        begin
            out_vld_reg <= last_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || proj.ready)
        begin
            proj_u_reg  <= u_next;
            proj_v_reg  <= v_next;
            invalid_reg <= fin_inv;
        end
    end

    assign proj.valid   = out_vld_reg;
    assign proj.proj_u  = proj_u_reg;
    assign proj.proj_v  = proj_v_reg;
    assign proj.invalid = invalid_reg;

    // ---------------- assertions -------------------------------------------
    a_invalid_centered: assert property (@(posedge clk) disable iff (!rst_n)
        proj.valid && proj.invalid |-> proj.proj_u == HALF && proj.proj_v == HALF)
        else $error("invalid result not centered");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !pos.ready |-> proj.valid && !proj.ready)
        else $error("input stalled without a blocked result");

    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        s10_vld_reg && !s10_inv_reg |-> s10_q_reg >= Q_MIN)
        else $error("projection root below its lower bound");

    a_drain_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !en && s10_vld_reg |=> $stable(s10_q_reg))
        else $error("pipeline moved while stalled");
endmodule

// ===== sv/leap_sqrt_cell.sv =====
// ============================================================================
// leap_sqrt_cell
// One digit step of a floor square root; cells chain into a full root.
// ============================================================================
module leap_sqrt_cell #(
    parameter int IW   = 64,
    parameter int STEP = 0,
    parameter int SW   = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vld_i,
    input  logic [IW-1:0] a_i,
    input  logic [IW-1:0] res_i,
    input  logic [SW-1:0] side_i,
    output logic          vld_o,
    output logic [IW-1:0] a_o,
    output logic [IW-1:0] res_o,
    output logic [SW-1:0] side_o
);
    localparam logic [IW-1:0] BIT = IW'(1) << (IW - 2 - 2 * STEP);

    logic          vld_reg;
    logic [IW-1:0] a_reg, a_next;
    logic [IW-1:0] res_reg, res_next;
    logic [SW-1:0] side_reg;
    logic [IW-1:0] trial;

    always_comb
    begin
        trial = res_i + BIT;
        if (a_i >= trial)
        begin
            a_next   = a_i - trial;
            res_next = (res_i >> 1) + BIT;
        end
        else
        begin
            a_next   = a_i;
            res_next = res_i >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a_next;
            res_reg  <= res_next;
            side_reg <= side_i;
        end
    end

    assign vld_o  = vld_reg;
    assign a_o    = a_reg;
    assign res_o  = res_reg;
    assign side_o = side_reg;
endmodule

// ===== sv/leap_div_cell.sv =====
// ============================================================================
// leap_div_cell
// One restoring-division step; quotient bits shift in as dividend bits leave.
// ============================================================================
module leap_div_cell #(
    parameter int DW = 32,
    parameter int QW = 16,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vld_i,
    input  logic [DW-1:0] d_i,
    input  logic [DW-1:0] rem_i,
    input  logic [QW-1:0] lq_i,
    input  logic [SW-1:0] side_i,
    output logic          vld_o,
    output logic [DW-1:0] d_o,
    output logic [DW-1:0] rem_o,
    output logic [QW-1:0] lq_o,
    output logic [SW-1:0] side_o
);
    logic          vld_reg;
    logic [DW-1:0] d_reg;
    logic [DW-1:0] rem_reg, rem_next;
    logic [QW-1:0] lq_reg, lq_next;
    logic [SW-1:0] side_reg;
    logic [DW:0]   trial;
    logic          ge;

    always_comb
    begin
        trial    = {rem_i, lq_i[QW-1]};
        ge       = trial >= {1'b0, d_i};
        rem_next = ge ? DW'(trial - {1'b0, d_i}) : DW'(trial);
        lq_next  = {lq_i[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg    <= d_i;
            rem_reg  <= rem_next;
            lq_reg   <= lq_next;
            side_reg <= side_i;
        end
    end

    assign vld_o  = vld_reg;
    assign d_o    = d_reg;
    assign rem_o  = rem_reg;
    assign lq_o   = lq_reg;
    assign side_o = side_reg;
endmodule

// ===== tb/tb_lambert_equal_area_projector.sv =====
// ============================================================================
// tb_lambert_equal_area_projector
// Streams signed 3D positions through the projector and checks each result.
// ============================================================================
// A directed set covers the poles, the zero vector and the coordinate extremes.
// Random positions follow, over the full range, at small magnitudes and close
// to the poles. A bit-exact fixed-point projection runs on every accepted
// request. Its result is queued and compared with each result the block
// returns. The sender works in bursts with gaps, and the receiver stalls in
// phases of its own.
module tb_lambert_equal_area_projector;
    import leap_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int OB = OUT_FRAC_BITS_DEF;
    localparam int N_RANDOM = 1500;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
    } point_t;

    typedef struct packed {
        logic [OB-1:0] u;
        logic [OB-1:0] v;
        logic          invalid;
    } uv_t;

    logic clk;
    logic rst_n;

    leap_pos_if  #(.COORD_BITS(CB))     pos ();
    leap_proj_if #(.OUT_FRAC_BITS(OB))  proj ();

    lambert_equal_area_projector #(
        .COORD_BITS    (CB),
        .OUT_FRAC_BITS (OB)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pos   (pos.sink),
        .proj  (proj.source)
    );

    point_t point_queue[$];
    uv_t    expected_uv[$];
    int     n_errors;
    int     cycle_cnt;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---------------- projection predictor ----------------
    function automatic longint unsigned floor_sqrt(input longint unsigned a);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > a)
            b = b >> 2;
        while (b != 0)
        begin
            if (a >= res + b)
            begin
                a = a - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Shift all magnitudes together until the largest lies in [2^14, 2^15].
    function automatic void scale_window(inout longint unsigned m0, inout longint unsigned m1,
                                         inout longint unsigned m2);
        longint unsigned mx;
        mx = m0;
        if (m1 > mx) mx = m1;
        if (m2 > mx) mx = m2;
        if (mx == 0)
            return;
        while (mx > 64'd32768)
        begin
            m0 = m0 >> 1; m1 = m1 >> 1; m2 = m2 >> 1; mx = mx >> 1;
        end
        while (mx < 64'd16384)
        begin
            m0 = m0 << 1; m1 = m1 << 1; m2 = m2 << 1; mx = mx << 1;
        end
    endfunction

    function automatic logic [OB-1:0] place_coord(input longint unsigned mag, input bit neg,
                                                  input longint unsigned q);
        longint unsigned off;
        longint res;
        off = ((mag << (14 + OB)) + (q >> 1)) / q;
        res = neg ? (longint'(1) << (OB - 1)) - longint'(off)
                  : (longint'(1) << (OB - 1)) + longint'(off);
        if (res < 0) res = 0;
        if (res > (longint'(1) << OB) - 1) res = (longint'(1) << OB) - 1;
        return res[OB-1:0];
    endfunction

    function automatic uv_t project_point(input point_t p);
        uv_t r;
        longint x, y, z;
        longint unsigned fx, fy, fz, px, py, dummy, rho, zs, q, s, w;
        x = longint'(p.x); y = longint'(p.y); z = longint'(p.z);
        if (x == 0 && y == 0 && z >= 0)
        begin
            r.u = OB'(1) << (OB - 1);
            r.v = OB'(1) << (OB - 1);
            r.invalid = 1'b1;
            return r;
        end
        fx = (x < 0) ? -x : x;
        fy = (y < 0) ? -y : y;
        fz = (z < 0) ? -z : z;
        px = fx; py = fy; dummy = 0;
        scale_window(fx, fy, fz);
        s = fx * fx + fy * fy + fz * fz;
        rho = floor_sqrt(s << 32);
        zs = fz << 16;
        if (z > 0)
        begin
            w = (rho << 30) / (rho + zs);
            scale_window(px, py, dummy);
            q = floor_sqrt(64'd2 * (px * px + py * py) * w);
        end
        else
        begin
            q = floor_sqrt(rho * ((rho + zs) >> 1));
            px = fx;
            py = fy;
        end
        r.u = place_coord(px, x < 0, q);
        r.v = place_coord(py, y < 0, q);
        r.invalid = 1'b0;
        return r;
    endfunction

    // ---------------- request driver ----------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos.valid  <= 1'b0;
            pos.pos_x  <= '0;
            pos.pos_y  <= '0;
            pos.pos_z  <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!pos.valid || pos.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left  <= gap_left - 1;
                pos.valid <= 1'b0;
            end
            else if (point_queue.size() > 0)
            begin
                point_t p;
                p = point_queue.pop_front();
                pos.pos_x <= p.x;
                pos.pos_y <= p.y;
                pos.pos_z <= p.z;
                pos.valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                pos.valid <= 1'b0;
        end
    end

    // ---------------- result receiver ----------------
    int stall_mode;
    int mode_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proj.ready <= 1'b0;
            stall_mode <= 0;
            mode_left  <= 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(20, 300);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0: proj.ready <= 1'b1;
                1: proj.ready <= 1'($urandom_range(0, 1));
                2: proj.ready <= ($urandom_range(0, 7) == 0);
                default: proj.ready <= ($urandom_range(0, 15) != 0);
            endcase
        end
    end

    // ---------------- monitor and checker ----------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_cnt <= cycle_cnt + 1;
            if (pos.valid && pos.ready)
            begin
                point_t p;
                p.x = pos.pos_x; p.y = pos.pos_y; p.z = pos.pos_z;
                expected_uv.push_back(project_point(p));
            end
            if (proj.valid && proj.ready)
            begin
                uv_t exp_r;
                if (expected_uv.size() == 0)
                begin
                    $display("%0t: unexpected result u=%0d v=%0d invalid=%0b", $time,
                             proj.proj_u, proj.proj_v, proj.invalid);
                    n_errors <= n_errors + 1;
                end
                else
                begin
                    exp_r = expected_uv.pop_front();
                    if (proj.proj_u !== exp_r.u || proj.proj_v !== exp_r.v ||
                        proj.invalid !== exp_r.invalid)
                    begin
                        $display("%0t: mismatch expected u=%0d v=%0d invalid=%0b,",
                                 $time, exp_r.u, exp_r.v, exp_r.invalid,
                                 " actual u=%0d v=%0d invalid=%0b",
                                 proj.proj_u, proj.proj_v, proj.invalid);
                        n_errors <= n_errors + 1;
                    end
                end
            end
            if (cycle_cnt > CYCLE_LIMIT)
            begin
                $display("lambert_equal_area_projector verification failed");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic void add_point(input int x, input int y, input int z);
        point_t p;
        p.x = CB'(x); p.y = CB'(y); p.z = CB'(z);
        point_queue.push_back(p);
    endfunction

    function automatic int rand_coord(input int kind);
        int m;
        case (kind)
            0: return $signed(CB'($urandom));
            1:
            begin
                m = $urandom_range(0, 15);
                return $signed(CB'($urandom)) >>> m;
            end
            default: return $urandom_range(0, 6) - 3;
        endcase
    endfunction

    initial
    begin
        int k;
        int kind;
        n_errors  = 0;
        cycle_cnt = 0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // zero vector, both poles, axis and extreme corners
        add_point(0, 0, 0);
        add_point(0, 0, 1);
        add_point(0, 0, 32767);
        add_point(0, 0, -1);
        add_point(0, 0, -32768);
        add_point(32767, 0, 0);
        add_point(-32768, 0, 0);
        add_point(0, 32767, 0);
        add_point(0, -32768, 0);
        add_point(32767, 32767, 32767);
        add_point(-32768, -32768, -32768);
        add_point(32767, -32768, 32767);
        add_point(-32768, 32767, -32768);
        add_point(1, 0, 32767);
        add_point(-1, 1, 32767);
        add_point(1, 1, -32768);
        add_point(1, 0, 0);
        add_point(-1, -1, -1);
        add_point(32767, 0, -32768);
        add_point(-32768, 0, 32767);
        add_point(16384, 16384, 0);
        add_point(3, -5, 7);
        add_point(-32768, -32768, 1);

        for (k = 0; k < N_RANDOM; k++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
                add_point(rand_coord(0), rand_coord(0), rand_coord(0));
            else if (kind < 8)
                add_point(rand_coord(1), rand_coord(1), rand_coord(1));
            else
                // near a pole: tiny x and y against a large z
                add_point(rand_coord(2), rand_coord(2),
                          ($urandom_range(0, 1) ? 32767 - $urandom_range(0, 200)
                                                : -32768 + $urandom_range(0, 200)));
        end

        wait (point_queue.size() == 0 && !pos.valid);
        wait (expected_uv.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_uv.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_uv.size());
            n_errors = n_errors + 1;
        end
        if (n_errors == 0)
            $display("lambert_equal_area_projector verification clean");
        else
            $display("lambert_equal_area_projector verification failed");
        $finish;
    end
endmodule
